FILE: hdl/ymodem_packet_deframer_assert.svh
// assertion macros for the ymodem packet deframer
`ifndef YMODEM_PACKET_DEFRAMER_ASSERT_SVH
`define YMODEM_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define YMDF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ymdf assertion failed");

// next-cycle implication
`define YMDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ymdf assertion failed");

`endif

FILE: hdl/ymdf_pkg.sv
// shared types, codes and crc function for the ymodem packet deframer
package ymdf_pkg;

   localparam int unsigned COUNT_W = 11;
   localparam logic [COUNT_W-1:0] SMALL_PAYLOAD = 11'd128;
   localparam logic [COUNT_W-1:0] LARGE_PAYLOAD = 11'd1024;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0] SOH_CODE     = 8'h01;
   localparam logic [7:0] STX_CODE     = 8'h02;
   localparam logic [7:0] EOT_CODE     = 8'h04;
   localparam logic [7:0] CAN_CODE     = 8'h18;
   localparam logic [7:0] ABORT_UPPER  = 8'h41;
   localparam logic [7:0] ABORT_LOWER  = 8'h61;

   localparam logic [2:0] V_OK128  = 3'd0;
   localparam logic [2:0] V_OK1024 = 3'd1;
   localparam logic [2:0] V_EOT    = 3'd2;
   localparam logic [2:0] V_CANCEL = 3'd3;
   localparam logic [2:0] V_ABORT  = 3'd4;
   localparam logic [2:0] V_ERROR  = 3'd5;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;
   localparam logic TYPE_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_CA   = 3'd1,
      PH_SEQ  = 3'd2,
      PH_COMP = 3'd3,
      PH_DATA = 3'd4,
      PH_CRCH = 3'd5,
      PH_CRCL = 3'd6
   } phase_type;

   typedef struct packed {
      logic clear;
      logic update;
   } crc_ctl_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] payload_byte;
      logic [2:0] verdict;
      logic [7:0] sequence_number;
      logic       last;
   } result_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: hdl/ymodem_packet_deframer.sv
// ymodem packet deframer top level: input register, state machine, result register
// an accepted word waits in the input register until the result register can take its result
// throughput: one word per cycle unless rsp_tready stalls the result register
// reset: synchronous active-high reset returns to idle with crc, counters cleared
module ymodem_packet_deframer
   import ymdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] payload_byte, [10:8] verdict, [18:11] sequence_number
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // last
);

   logic        in_valid_ff, in_valid_in;
   logic        in_type_ff;
   logic [7:0]  in_byte_ff;
   logic        fire;
   logic        load;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   result_type  result;
   crc_ctl_type crc_ctl;
   logic [15:0] crc;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign load       = fire && result.valid;

   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = load ? 1'b1 : ((out_valid_ff && rsp_tready) ? 1'b0 : out_valid_ff);

   ymdf_crc16 u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .data  (in_byte_ff),
      .crc   (crc)
   );

   ymdf_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_type (in_type_ff),
      .in_byte (in_byte_ff),
      .crc     (crc),
      .crc_ctl (crc_ctl),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_type_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (load) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {5'b0, out_ff.sequence_number, out_ff.verdict, out_ff.payload_byte};

`include "ymodem_packet_deframer_assert.svh"

   `YMDF_ASSERT_NOW(a_verdict_range, clock, reset, rsp_tvalid, rsp_tdata[10:8] <= V_ERROR)
   `YMDF_ASSERT_NOW(a_last_on_verdict, clock, reset, rsp_tvalid, rsp_tlast == rsp_tuser)
   `YMDF_ASSERT_NEXT(a_load_shows, clock, reset, load, out_valid_ff)
   `YMDF_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !fire, in_valid_ff)

endmodule

FILE: hdl/ymdf_crc16.sv
// running crc-16/xmodem register over payload bytes
module ymdf_crc16
   import ymdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   input  logic [7:0]  data,
   output logic [15:0] crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      priority if (ctl.clear) begin
         crc_in = '0;
      end else if (ctl.update) begin
         crc_in = crc_step(crc_ff, data);
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

FILE: hdl/ymdf_ctrl.sv
// packet state machine, header check and verdict logic
module ymdf_ctrl
   import ymdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic        in_type,
   input  logic [7:0]  in_byte,
   input  logic [15:0] crc,
   output crc_ctl_type crc_ctl,
   output result_type  result
);

   phase_type           phase_ff, phase_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [7:0]          seq_ff, seq_in;
   logic                big_ff, big_in;
   logic [7:0]          crch_ff, crch_in;
   logic                hbad_ff, hbad_in;
   logic [COUNT_W-1:0]  count_inc;
   logic [COUNT_W-1:0]  size;
   logic                in_packet;

   assign count_inc = count_ff + 1'b1;
   assign size      = big_ff ? LARGE_PAYLOAD : SMALL_PAYLOAD;
   assign in_packet = (phase_ff == PH_SEQ) || (phase_ff == PH_COMP) ||
                      (phase_ff == PH_DATA) || (phase_ff == PH_CRCH) ||
                      (phase_ff == PH_CRCL);

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      seq_in   = seq_ff;
      big_in   = big_ff;
      crch_in  = crch_ff;
      hbad_in  = hbad_ff;
      crc_ctl  = '0;
      if (fire) begin
         if (in_type == TYPE_TIMEOUT) begin
            phase_in = PH_IDLE;
         end else begin
            unique case (phase_ff)
               PH_CA: begin
                  phase_in = PH_IDLE;
               end
               PH_SEQ: begin
                  seq_in   = in_byte;
                  phase_in = PH_COMP;
               end
               PH_COMP: begin
                  hbad_in     = ((seq_ff ^ in_byte) != 8'hff);
                  count_in    = '0;
                  crc_ctl.clear = 1'b1;
                  phase_in    = PH_DATA;
               end
               PH_DATA: begin
                  crc_ctl.update = 1'b1;
                  count_in = count_inc;
                  if (count_inc >= size) begin
                     phase_in = PH_CRCH;
                  end
               end
               PH_CRCH: begin
                  crch_in  = in_byte;
                  phase_in = PH_CRCL;
               end
               PH_CRCL: begin
                  phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
                  unique case (in_byte)
                     SOH_CODE, STX_CODE: begin
                        big_in        = (in_byte == STX_CODE);
                        seq_in        = '0;
                        hbad_in       = 1'b0;
                        count_in      = '0;
                        crc_ctl.clear = 1'b1;
                        phase_in      = PH_SEQ;
                     end
                     CAN_CODE: begin
                        phase_in = PH_CA;
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            endcase
         end
      end
   end

   // result for the current word
   always_comb begin
      result = '0;
      if (in_type == TYPE_TIMEOUT) begin
         result.valid           = 1'b1;
         result.kind            = KIND_VERDICT;
         result.verdict         = V_ERROR;
         result.sequence_number = in_packet ? seq_ff : 8'h00;
         result.last            = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_CA: begin
               result.valid   = 1'b1;
               result.kind    = KIND_VERDICT;
               result.verdict = (in_byte == CAN_CODE) ? V_CANCEL : V_ERROR;
               result.last    = 1'b1;
            end
            PH_SEQ, PH_COMP, PH_CRCH: begin
               result.valid = 1'b0;
            end
            PH_DATA: begin
               result.valid        = 1'b1;
               result.kind         = KIND_PAYLOAD;
               result.payload_byte = in_byte;
            end
            PH_CRCL: begin
               result.valid           = 1'b1;
               result.kind            = KIND_VERDICT;
               result.sequence_number = seq_ff;
               result.last            = 1'b1;
               if (hbad_ff || ({crch_ff, in_byte} != crc)) begin
                  result.verdict = V_ERROR;
               end else begin
                  result.verdict = big_ff ? V_OK1024 : V_OK128;
               end
            end
            default: begin
               unique case (in_byte)
                  SOH_CODE, STX_CODE, CAN_CODE: begin
                     result.valid = 1'b0;
                  end
                  EOT_CODE: begin
                     result.valid   = 1'b1;
                     result.kind    = KIND_VERDICT;
                     result.verdict = V_EOT;
                     result.last    = 1'b1;
                  end
                  ABORT_UPPER, ABORT_LOWER: begin
                     result.valid   = 1'b1;
                     result.kind    = KIND_VERDICT;
                     result.verdict = V_ABORT;
                     result.last    = 1'b1;
                  end
                  default: begin
                     result.valid   = 1'b1;
                     result.kind    = KIND_VERDICT;
                     result.verdict = V_ERROR;
                     result.last    = 1'b1;
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         seq_ff   <= '0;
         big_ff   <= 1'b0;
         crch_ff  <= '0;
         hbad_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         seq_ff   <= seq_in;
         big_ff   <= big_in;
         crch_ff  <= crch_in;
         hbad_ff  <= hbad_in;
      end
   end

endmodule
